// ===== rtl/core/clbm_pkg.sv =====
// shared types and constants for the chr latch bank mapper
package clbm_pkg;

  // memory target of a translated access
  typedef enum logic [1:0] {
    SEL_NONE    = 2'd0,
    SEL_CHR     = 2'd1,
    SEL_PRG_RAM = 2'd2,
    SEL_PRG_ROM = 2'd3
  } mem_sel_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRG_ROM_BANKS_LOG2 = 2'd0,
    CFG_CHR_SIZE_LOG2      = 2'd1,
    CFG_CHR_IS_RAM         = 2'd2,
    CFG_PRG_RAM_SIZE_LOG2  = 2'd3
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 5;

  // request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // latch trigger addresses
  localparam logic [15:0] ADDR_LO_FD       = 16'h0FD8;
  localparam logic [15:0] ADDR_LO_FE       = 16'h0FE8;
  localparam logic [15:0] ADDR_HI_FD_FIRST = 16'h1FD8;
  localparam logic [15:0] ADDR_HI_FD_LAST  = 16'h1FDF;
  localparam logic [15:0] ADDR_HI_FE_FIRST = 16'h1FE8;
  localparam logic [15:0] ADDR_HI_FE_LAST  = 16'h1FEF;

  // register write windows, by top address nibble
  localparam logic [3:0] REG_PRG_BANK    = 4'hA;
  localparam logic [3:0] REG_CHR_FD_LOW  = 4'hB;
  localparam logic [3:0] REG_CHR_FE_LOW  = 4'hC;
  localparam logic [3:0] REG_CHR_FD_HIGH = 4'hD;
  localparam logic [3:0] REG_CHR_FE_HIGH = 4'hE;
  localparam logic [3:0] REG_MIRROR      = 4'hF;

  // clamps for oversized size settings
  localparam logic [2:0] PRG_ROM_LOG2_MAX = 3'd4;
  localparam logic [4:0] CHR_LOG2_MAX     = 5'd17;
  localparam logic [3:0] PRG_RAM_LOG2_MAX = 4'd13;

  typedef struct packed {
    logic [2:0] prg_rom_banks_log2;
    logic [4:0] chr_size_log2;
    logic       chr_is_ram;
    logic [3:0] prg_ram_size_log2;
  } cfg_t;

  typedef struct packed {
    logic [3:0] prg_bank;
    logic [4:0] chr_bank_fd_low;
    logic [4:0] chr_bank_fe_low;
    logic [4:0] chr_bank_fd_high;
    logic [4:0] chr_bank_fe_high;
    logic       mirror_bit;
    logic       latch_low_is_fe;
    logic       latch_high_is_fe;
  } bank_state_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    mem_sel_t    mem_select;
    logic        mem_write;
    logic [16:0] mem_index;
    logic [7:0]  mem_write_data;
    logic [1:0]  mirror_code;
  } result_t;

endpackage

// ===== rtl/core/clbm_if.sv =====
// valid/ready channel interfaces for bus requests and translated results
interface clbm_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output req_type, output address, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input address, input write_data,
                output ready);
endinterface

interface clbm_out_if;
  import clbm_pkg::*;
  logic        valid;
  logic        ready;
  mem_sel_t    mem_select;
  logic        mem_write;
  logic [16:0] mem_index;
  logic [7:0]  mem_write_data;
  logic [1:0]  mirror_code;

  modport source (output valid, output mem_select, output mem_write, output mem_index,
                  output mem_write_data, output mirror_code, input ready);
  modport sink (input valid, input mem_select, input mem_write, input mem_index,
                input mem_write_data, input mirror_code, output ready);
endinterface

// ===== rtl/core/chr_latch_bank_mapper.sv =====
// top level of the chr latch bank mapper: request register, decode, result register
//
// Usage:
//   in_ch carries one bus access per transaction (req_type, address, write_data).
//   out_ch carries one translated result per transaction: memory target, write
//   flag, byte index, write byte and the current mirroring code.
//   cfg_we/cfg_index/cfg_wdata write the four size registers; write them only
//   while no access is in flight.
// Timing:
//   an access taken is held in the request register, decoded combinationally
//   and its result is registered in the result register. One access per cycle
//   is taken sustained while out_ch.ready stays high; the only loop is the bank
//   and latch registers, which are updated in the same cycle as the decode.
// Reset:
//   rst_n low clears both valid flags, zeroes the bank registers and mirroring,
//   sets both latches to FE and loads the default sizes.
// Back-pressure:
//   while out_ch.ready is low the result holds; the request register still
//   takes one more access, after which in_ch.ready drops until out_ch moves.
module chr_latch_bank_mapper (
  input  logic                 clk,
  input  logic                 rst_n,
  clbm_in_if.sink              in_ch,
  clbm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  clbm_pkg::cfg_idx_t   cfg_index,
  input  logic [clbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import clbm_pkg::*;

  cfg_t        cfg_r;
  bank_state_t st_r;
  bank_state_t st_nxt;
  req_t        s1_req_r;
  logic        s1_valid_r;
  result_t     res;
  result_t     out_r;
  logic        out_valid_r;
  logic        s1_adv;
  logic        s1_fire;
  logic        in_fire;

  // handshake control
  assign s1_adv       = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && s1_adv;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_rom_banks_log2 <= 3'd4;
      cfg_r.chr_size_log2      <= 5'd17;
      cfg_r.chr_is_ram         <= 1'b0;
      cfg_r.prg_ram_size_log2  <= 4'd13;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_ROM_BANKS_LOG2: cfg_r.prg_rom_banks_log2 <= cfg_wdata[2:0];
        CFG_CHR_SIZE_LOG2:      cfg_r.chr_size_log2      <= cfg_wdata[4:0];
        CFG_CHR_IS_RAM:         cfg_r.chr_is_ram         <= cfg_wdata[0];
        CFG_PRG_RAM_SIZE_LOG2:  cfg_r.prg_ram_size_log2  <= cfg_wdata[3:0];
        default:                cfg_r                    <= cfg_r;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.req_type   <= in_ch.req_type;
      s1_req_r.address    <= in_ch.address;
      s1_req_r.write_data <= in_ch.write_data;
    end
  end

  clbm_decode u_decode (
    .cfg    (cfg_r),
    .st     (st_r),
    .req    (s1_req_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // bank, mirroring and latch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{prg_bank: 4'd0, chr_bank_fd_low: 5'd0, chr_bank_fe_low: 5'd0,
                chr_bank_fd_high: 5'd0, chr_bank_fe_high: 5'd0, mirror_bit: 1'b0,
                latch_low_is_fe: 1'b1, latch_high_is_fe: 1'b1};
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mem_select     = out_r.mem_select;
  assign out_ch.mem_write      = out_r.mem_write;
  assign out_ch.mem_index      = out_r.mem_index;
  assign out_ch.mem_write_data = out_r.mem_write_data;
  assign out_ch.mirror_code    = out_r.mirror_code;

  // unselected results carry a zero index
  a_none_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.mem_select == SEL_NONE) |-> out_r.mem_index == '0)
    else $error("unselected result with nonzero index");

  // only chr and prg ram are ever written
  a_write_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.mem_write) |->
      (out_r.mem_select == SEL_CHR || out_r.mem_select == SEL_PRG_RAM))
    else $error("write flagged for a read-only target");

  // write accesses never move the latches
  a_latch_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_req_r.req_type == REQ_WRITE) |=>
      ($stable(st_r.latch_low_is_fe) && $stable(st_r.latch_high_is_fe)))
    else $error("latch moved on a write access");

  // state only changes when a request leaves the request register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(st_r))
    else $error("bank state changed without a transaction");

  // input stalls only when both stages are full and the output is blocked
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without back-pressure");

endmodule

// ===== rtl/core/clbm_decode.sv =====
// address decode, bank translation and next bank/latch state for one access
module clbm_decode (
  input  clbm_pkg::cfg_t        cfg,
  input  clbm_pkg::bank_state_t st,
  input  clbm_pkg::req_t        req,
  output clbm_pkg::result_t     res,
  output clbm_pkg::bank_state_t st_nxt
);
  import clbm_pkg::*;

  logic [4:0]  chr_l;
  logic [3:0]  ram_l;
  logic [2:0]  rom_l;
  logic [16:0] chr_mask;
  logic [12:0] ram_mask;
  logic [3:0]  banks_m1;
  logic [4:0]  chr_bank;
  logic [3:0]  rom_bank;
  logic [15:0] addr;

  assign addr = req.address;

  // clamp size settings and build index masks
  assign chr_l    = (cfg.chr_size_log2 > CHR_LOG2_MAX) ? CHR_LOG2_MAX : cfg.chr_size_log2;
  assign ram_l    = (cfg.prg_ram_size_log2 > PRG_RAM_LOG2_MAX) ? PRG_RAM_LOG2_MAX
                                                               : cfg.prg_ram_size_log2;
  assign rom_l    = (cfg.prg_rom_banks_log2 > PRG_ROM_LOG2_MAX) ? PRG_ROM_LOG2_MAX
                                                                : cfg.prg_rom_banks_log2;
  assign chr_mask = ~(17'h1FFFF << chr_l);
  assign ram_mask = ~(13'h1FFF << ram_l);
  assign banks_m1 = 4'((5'd1 << rom_l) - 5'd1);

  // chr bank picked by the latch as it stands before this read
  always_comb begin
    if (!addr[12]) begin
      chr_bank = st.latch_low_is_fe ? st.chr_bank_fe_low : st.chr_bank_fd_low;
    end else begin
      chr_bank = st.latch_high_is_fe ? st.chr_bank_fe_high : st.chr_bank_fd_high;
    end
  end

  // prg rom bank: switchable window, then the last three banks wrapped to the count
  always_comb begin
    case (addr[14:13])
      2'b00:   rom_bank = st.prg_bank & banks_m1;
      2'b01:   rom_bank = (banks_m1 - 4'd2) & banks_m1;
      2'b10:   rom_bank = (banks_m1 - 4'd1) & banks_m1;
      default: rom_bank = banks_m1;
    endcase
  end

  // access decode and state update
  always_comb begin
    res.mem_select     = SEL_NONE;
    res.mem_write      = 1'b0;
    res.mem_index      = '0;
    res.mem_write_data = '0;
    st_nxt             = st;
    if (addr[15:13] == 3'b000) begin
      if (req.req_type == REQ_WRITE) begin
        if (cfg.chr_is_ram) begin
          res.mem_select     = SEL_CHR;
          res.mem_write      = 1'b1;
          res.mem_index      = {4'd0, addr[12:0]} & chr_mask;
          res.mem_write_data = req.write_data;
        end
      end else begin
        res.mem_select = SEL_CHR;
        res.mem_index  = {chr_bank, addr[11:0]} & chr_mask;
        if (addr == ADDR_LO_FD) begin
          st_nxt.latch_low_is_fe = 1'b0;
        end else if (addr == ADDR_LO_FE) begin
          st_nxt.latch_low_is_fe = 1'b1;
        end else if (addr inside {[ADDR_HI_FD_FIRST:ADDR_HI_FD_LAST]}) begin
          st_nxt.latch_high_is_fe = 1'b0;
        end else if (addr inside {[ADDR_HI_FE_FIRST:ADDR_HI_FE_LAST]}) begin
          st_nxt.latch_high_is_fe = 1'b1;
        end
      end
    end else if (addr[15:13] == 3'b011) begin
      res.mem_select = SEL_PRG_RAM;
      res.mem_index  = {4'd0, addr[12:0] & ram_mask};
      if (req.req_type == REQ_WRITE) begin
        res.mem_write      = 1'b1;
        res.mem_write_data = req.write_data;
      end
    end else if (addr[15]) begin
      if (req.req_type == REQ_WRITE) begin
        case (addr[15:12])
          REG_PRG_BANK:    st_nxt.prg_bank         = req.write_data[3:0];
          REG_CHR_FD_LOW:  st_nxt.chr_bank_fd_low  = req.write_data[4:0];
          REG_CHR_FE_LOW:  st_nxt.chr_bank_fe_low  = req.write_data[4:0];
          REG_CHR_FD_HIGH: st_nxt.chr_bank_fd_high = req.write_data[4:0];
          REG_CHR_FE_HIGH: st_nxt.chr_bank_fe_high = req.write_data[4:0];
          REG_MIRROR:      st_nxt.mirror_bit       = req.write_data[0];
          default:         st_nxt.prg_bank         = st.prg_bank;
        endcase
      end else begin
        res.mem_select = SEL_PRG_ROM;
        res.mem_index  = {rom_bank, addr[12:0]};
      end
    end
    res.mirror_code = {1'b1, st_nxt.mirror_bit};
  end

endmodule
